// File: hw/rtl/mlfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the four-level feedback-queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int SLOTS       = 32;
    localparam int SLOT_W      = 5;
    localparam int QDEPTH      = 32;
    localparam int QPTR_W      = 5;
    localparam int QCNT_W      = 6;
    localparam int LEVELS      = 4;
    localparam int DEF_TASKS   = 32;
    localparam logic [7:0] DEF_TIMEOUT = 8'd20;

    localparam logic [1:0] LVL_RT  = 2'd0;
    localparam logic [1:0] LVL_MAX = 2'd3;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Slot status codes.
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_QUEUED  = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_STALE   = 2'd3;

    // Result event codes.
    localparam logic [2:0] EV_IDLE     = 3'd0;
    localparam logic [2:0] EV_FINISHED = 3'd1;
    localparam logic [2:0] EV_DEMOTED  = 3'd2;
    localparam logic [2:0] EV_RT_CONT  = 3'd3;
    localparam logic [2:0] EV_TIMEOUT  = 3'd4;
    localparam logic [2:0] EV_ACCEPTED = 3'd5;
    localparam logic [2:0] EV_REJECTED = 3'd6;

    typedef struct packed {
        logic        started;
        logic [1:0]  level;
        logic [15:0] remaining;
        logic [15:0] arrival;
    } t_slot;

    typedef struct packed {
        logic [4:0]  task_id;
        logic [2:0]  ev;
        logic        first;
        logic [1:0]  level;
        logic [15:0] remaining;
    } t_res;

    // Queue control from the sequencer.
    typedef struct packed {
        logic       push;
        logic [1:0] push_lvl;
        logic [4:0] push_slot;
        logic       rd;
        logic       adv;
        logic [1:0] pop_lvl;
    } t_q_ctrl;

    typedef struct packed {
        logic [LEVELS-1:0] empty;
        logic [LEVELS-1:0] full;
    } t_q_stat;

endpackage

// File: hw/rtl/mlfq_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_slot_mem
// Per-slot task record memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mlfq_slot_mem (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [4:0]           i_waddr,
    input  mlfq_pkg::t_slot      i_wdata,
    input  logic [4:0]           i_raddr,
    output mlfq_pkg::t_slot      o_rdata
);
    import mlfq_pkg::*;

    t_slot r_mem [0:SLOTS-1];
    t_slot r_q;

    // Synchronous write and read; a read sees writes of earlier edges.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// File: hw/rtl/mlfq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_queue
// Four circular FIFO levels sharing one entry memory, with head, tail and
// count registers per level.
// ----------------------------------------------------------------------------
module mlfq_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mlfq_pkg::t_q_ctrl    i_ctrl,
    output mlfq_pkg::t_q_stat    o_stat,
    output logic [4:0]           o_rd_slot
);
    import mlfq_pkg::*;

    logic [SLOT_W-1:0] r_mem [0:LEVELS*QDEPTH-1];
    logic [SLOT_W-1:0] r_rd;
    logic [QPTR_W-1:0] r_head  [0:LEVELS-1];
    logic [QPTR_W-1:0] r_tail  [0:LEVELS-1];
    logic [QCNT_W-1:0] r_count [0:LEVELS-1];

    // Entry memory: push writes at the tail, a read fetches the head.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[{i_ctrl.push_lvl, r_tail[i_ctrl.push_lvl]}] <= i_ctrl.push_slot;
        end
        if (i_ctrl.rd) begin
            r_rd <= r_mem[{i_ctrl.pop_lvl, r_head[i_ctrl.pop_lvl]}];
        end
    end

    // Pointer and count bookkeeping for every level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            for (int l = 0; l < LEVELS; l++) begin
                if (i_ctrl.push && (i_ctrl.push_lvl == 2'(l))) begin
                    r_tail[l] <= r_tail[l] + QPTR_W'(1);
                end
                if (i_ctrl.adv && (i_ctrl.pop_lvl == 2'(l))) begin
                    r_head[l] <= r_head[l] + QPTR_W'(1);
                end
                if ((i_ctrl.push && (i_ctrl.push_lvl == 2'(l))) &&
                    !(i_ctrl.adv && (i_ctrl.pop_lvl == 2'(l)))) begin
                    r_count[l] <= r_count[l] + QCNT_W'(1);
                end else if (!(i_ctrl.push && (i_ctrl.push_lvl == 2'(l))) &&
                             (i_ctrl.adv && (i_ctrl.pop_lvl == 2'(l)))) begin
                    r_count[l] <= r_count[l] - QCNT_W'(1);
                end
            end
        end
    end

    // Level status flags.
    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            o_stat.empty[l] = (r_count[l] == '0);
            o_stat.full[l]  = r_count[l][QCNT_W-1];
        end
    end

    assign o_rd_slot = r_rd;

endmodule

// File: hw/rtl/mlfq_task_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_task_scheduler_core
// Four-level feedback-queue task scheduler with timeout sweep.
// ----------------------------------------------------------------------------
// Usage: a request is taken at a rising edge with i_start high and o_busy
// low. An arrive request (i_op 0) files a slot and answers accepted or
// rejected with one result on the cycle after it is taken; o_busy stays low,
// so arrive requests can follow each other every cycle.
// A tick request (i_op 1) runs one task for one unit, then sweeps every live
// slot for timeouts. It keeps o_busy high while it selects the task (a
// real-time task that continues, or a search of levels 0 to 3 that skips
// stale queue entries), runs it and sweeps the slot memory, one slot per
// cycle. The final result appears in the same cycle as o_busy falls.
// Results come at most one per cycle, each marked by o_result_valid for one
// cycle, o_last on the final one; the receiver takes each result as it
// appears and cannot stall the block.
// Configuration: i_cfg_valid with i_cfg_timeout_limit writes the timeout limit;
// o_cfg_ready is always high; the user makes writes only while idle (unchecked).
// Reset (synchronous, i_rst_n low) frees all slots, empties the queues,
// clears the time counter and sets the timeout limit to 20.
// ----------------------------------------------------------------------------
module mlfq_task_scheduler_core #(
    parameter int TASKS = mlfq_pkg::DEF_TASKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_op,
    input  logic [4:0]  i_task_id,
    input  logic [1:0]  i_priority_req,
    input  logic [15:0] i_burst,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_timeout_limit,
    output logic        o_result_valid,
    output logic [4:0]  o_result_task,
    output logic [2:0]  o_event_res,
    output logic        o_first_run,
    output logic [1:0]  o_level,
    output logic [15:0] o_remaining,
    output logic [15:0] o_now,
    output logic        o_last
);
    import mlfq_pkg::*;

    localparam int LIVE = (TASKS < SLOTS) ? TASKS : SLOTS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEL   = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_POPW  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_RUN   = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_FLUSH = 3'd7;

    // Control registers.
    logic [2:0]  r_state, n_state;
    logic [7:0]  r_limit;
    logic [15:0] r_time, n_time;
    logic        r_rt_act, n_rt_act;
    logic [4:0]  r_rt_cur, n_rt_cur;
    logic [1:0]  r_lvl, n_lvl;
    logic [4:0]  r_sel, n_sel;
    logic        r_sel_v, n_sel_v;
    logic        r_rt, n_rt;
    logic [4:0]  r_idx, n_idx;
    logic        r_done, n_done;
    logic        r_chk_v, n_chk_v;
    logic [4:0]  r_chk_idx, n_chk_idx;
    t_res        r_pend, n_pend;
    logic [1:0]  r_status [0:SLOTS-1];

    // Output registers.
    logic        r_o_valid, n_o_valid;
    t_res        r_o_res, n_o_res;
    logic [15:0] r_o_now, n_o_now;
    logic        r_o_last, n_o_last;

    // Status write port and read mux.
    logic        st_we;
    logic [4:0]  st_widx;
    logic [1:0]  st_wval;
    logic [4:0]  st_ridx;
    logic [1:0]  st_rd;

    // Memory and queue connections.
    logic        sm_we;
    logic [4:0]  sm_waddr;
    t_slot       sm_wdata;
    logic [4:0]  sm_raddr;
    t_slot       sm_q;
    t_q_ctrl     q_ctrl;
    t_q_stat     q_stat;
    logic [4:0]  q_slot;

    // Run-step helpers.
    logic [15:0] run_rem;
    logic [15:0] age;
    logic [1:0]  dem_lvl;
    logic        accept;

    mlfq_slot_mem u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (sm_raddr),
        .o_rdata (sm_q)
    );

    mlfq_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (q_ctrl),
        .o_stat    (q_stat),
        .o_rd_slot (q_slot)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Status read address follows the state.
    always_comb begin
        unique case (r_state)
            S_IDLE:  st_ridx = i_task_id;
            S_SEL:   st_ridx = r_rt_cur;
            S_POPW:  st_ridx = q_slot;
            S_SCAN:  st_ridx = r_chk_idx;
            default: st_ridx = r_sel;
        endcase
        st_rd = r_status[st_ridx];
    end

    assign run_rem = sm_q.remaining - {15'd0, (sm_q.remaining != 16'd0)};
    assign age     = (r_state == S_RUN) ? (r_time + 16'd1 - sm_q.arrival)
                                        : (r_time - sm_q.arrival);
    assign dem_lvl = (sm_q.level == LVL_MAX) ? LVL_MAX : sm_q.level + 2'd1;
    assign accept  = (int'(i_task_id) < LIVE) && (st_rd == ST_FREE) &&
                     (i_burst != 16'd0) && !q_stat.full[i_priority_req];

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_time    = r_time;
        n_rt_act  = r_rt_act;
        n_rt_cur  = r_rt_cur;
        n_lvl     = r_lvl;
        n_sel     = r_sel;
        n_sel_v   = r_sel_v;
        n_rt      = r_rt;
        n_idx     = r_idx;
        n_done    = r_done;
        n_chk_v   = 1'b0;
        n_chk_idx = r_chk_idx;
        n_pend    = r_pend;
        n_o_valid = 1'b0;
        n_o_res   = r_o_res;
        n_o_now   = r_o_now;
        n_o_last  = r_o_last;
        st_we     = 1'b0;
        st_widx   = st_ridx;
        st_wval   = ST_FREE;
        sm_we     = 1'b0;
        sm_waddr  = r_sel;
        sm_wdata  = sm_q;
        sm_raddr  = r_sel;
        q_ctrl    = '0;
        q_ctrl.pop_lvl = r_lvl;

        unique case (r_state)
            S_IDLE: begin
                if (i_start && (i_op == OP_ARRIVE)) begin
                    n_o_valid       = 1'b1;
                    n_o_now         = r_time;
                    n_o_last        = 1'b1;
                    n_o_res.task_id = i_task_id;
                    n_o_res.first   = 1'b0;
                    if (accept) begin
                        st_we              = 1'b1;
                        st_wval            = ST_QUEUED;
                        sm_we              = 1'b1;
                        sm_waddr           = i_task_id;
                        sm_wdata.started   = 1'b0;
                        sm_wdata.level     = i_priority_req;
                        sm_wdata.remaining = i_burst;
                        sm_wdata.arrival   = r_time;
                        q_ctrl.push        = 1'b1;
                        q_ctrl.push_lvl    = i_priority_req;
                        q_ctrl.push_slot   = i_task_id;
                        n_o_res.ev         = EV_ACCEPTED;
                        n_o_res.level      = i_priority_req;
                        n_o_res.remaining  = i_burst;
                    end else begin
                        n_o_res.ev        = EV_REJECTED;
                        n_o_res.level     = LVL_RT;
                        n_o_res.remaining = 16'd0;
                    end
                end else if (i_start) begin
                    n_state = S_SEL;
                end
            end

            // Keep the current real-time task, or start popping level 0.
            S_SEL: begin
                if (r_rt_act && (st_rd == ST_RUNNING)) begin
                    n_sel   = r_rt_cur;
                    n_sel_v = 1'b1;
                    n_rt    = 1'b1;
                    n_state = S_RD;
                end else begin
                    n_rt_act = 1'b0;
                    n_rt     = 1'b0;
                    n_lvl    = LVL_RT;
                    n_state  = S_POP;
                end
            end

            // Fetch the head of the current level, or move to the next one.
            S_POP: begin
                if (q_stat.empty[r_lvl]) begin
                    if (r_lvl == LVL_MAX) begin
                        n_sel_v = 1'b0;
                        n_state = S_RUN;
                    end else begin
                        n_lvl = r_lvl + 2'd1;
                    end
                end else begin
                    q_ctrl.rd = 1'b1;
                    n_state   = S_POPW;
                end
            end

            // Consume the fetched entry; stale entries are dropped.
            S_POPW: begin
                q_ctrl.adv = 1'b1;
                n_state    = S_POP;
                if (st_rd == ST_QUEUED) begin
                    n_sel   = q_slot;
                    n_sel_v = 1'b1;
                    n_state = S_RD;
                    if (r_lvl == LVL_RT) begin
                        n_rt     = 1'b1;
                        n_rt_act = 1'b1;
                        n_rt_cur = q_slot;
                        st_we    = 1'b1;
                        st_wval  = ST_RUNNING;
                    end
                end else if (st_rd == ST_STALE) begin
                    st_we   = 1'b1;
                    st_wval = ST_FREE;
                end
            end

            S_RD: begin
                n_state = S_RUN;
            end

            // Run the selected task for one unit and advance time.
            S_RUN: begin
                n_time   = r_time + 16'd1;
                n_idx    = '0;
                n_done   = 1'b0;
                n_state  = S_SCAN;
                st_widx  = r_sel;
                if (!r_sel_v) begin
                    n_pend = '{task_id: 5'd0, ev: EV_IDLE, first: 1'b0,
                               level: LVL_RT, remaining: 16'd0};
                end else begin
                    sm_we              = 1'b1;
                    sm_wdata.started   = 1'b1;
                    sm_wdata.remaining = run_rem;
                    st_we              = 1'b1;
                    n_pend.task_id     = r_sel;
                    n_pend.first       = !sm_q.started;
                    n_pend.level       = sm_q.level;
                    n_pend.remaining   = run_rem;
                    if (run_rem == 16'd0) begin
                        st_wval    = ST_FREE;
                        n_pend.ev  = EV_FINISHED;
                        if (r_rt) begin
                            n_rt_act = 1'b0;
                        end
                    end else if (age >= {8'd0, r_limit}) begin
                        st_wval   = ST_FREE;
                        n_pend.ev = EV_TIMEOUT;
                        if (r_rt) begin
                            n_rt_act = 1'b0;
                        end
                    end else if (r_rt) begin
                        st_wval   = ST_RUNNING;
                        n_pend.ev = EV_RT_CONT;
                    end else begin
                        sm_wdata.level = dem_lvl;
                        n_pend.level   = dem_lvl;
                        if (!q_stat.full[dem_lvl]) begin
                            q_ctrl.push      = 1'b1;
                            q_ctrl.push_lvl  = dem_lvl;
                            q_ctrl.push_slot = r_sel;
                            st_wval          = ST_QUEUED;
                            n_pend.ev        = EV_DEMOTED;
                        end else begin
                            st_wval   = ST_FREE;
                            n_pend.ev = EV_TIMEOUT;
                        end
                    end
                end
            end

            // Sweep slots: read one slot per cycle, check it the next cycle.
            S_SCAN: begin
                sm_raddr = r_idx;
                if (!r_done) begin
                    n_chk_v   = 1'b1;
                    n_chk_idx = r_idx;
                    if (r_idx == 5'(LIVE - 1)) begin
                        n_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
                if (r_chk_v && ((st_rd == ST_QUEUED) || (st_rd == ST_RUNNING)) &&
                    (age >= {8'd0, r_limit})) begin
                    st_we   = 1'b1;
                    if (st_rd == ST_QUEUED) begin
                        st_wval = ST_STALE;
                    end else begin
                        st_wval  = ST_FREE;
                        n_rt_act = 1'b0;
                    end
                    // Release the previous result now that another follows.
                    n_o_valid = 1'b1;
                    n_o_res   = r_pend;
                    n_o_now   = r_time;
                    n_o_last  = 1'b0;
                    n_pend    = '{task_id: r_chk_idx, ev: EV_TIMEOUT, first: 1'b0,
                                  level: sm_q.level, remaining: sm_q.remaining};
                end
            end

            // Deliver the held result as the final one.
            S_FLUSH: begin
                n_o_valid = 1'b1;
                n_o_res   = r_pend;
                n_o_now   = r_time;
                n_o_last  = 1'b1;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= DEF_TIMEOUT;
            r_time    <= '0;
            r_rt_act  <= 1'b0;
            r_rt_cur  <= '0;
            r_chk_v   <= 1'b0;
            r_o_valid <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_status[s] <= ST_FREE;
            end
        end else begin
            r_state   <= n_state;
            r_time    <= n_time;
            r_rt_act  <= n_rt_act;
            r_rt_cur  <= n_rt_cur;
            r_chk_v   <= n_chk_v;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_timeout_limit;
            end
            if (st_we) begin
                r_status[st_widx] <= st_wval;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_lvl     <= n_lvl;
        r_sel     <= n_sel;
        r_sel_v   <= n_sel_v;
        r_rt      <= n_rt;
        r_idx     <= n_idx;
        r_done    <= n_done;
        r_chk_idx <= n_chk_idx;
        r_pend    <= n_pend;
        r_o_res   <= n_o_res;
        r_o_now   <= n_o_now;
        r_o_last  <= n_o_last;
    end

    assign o_result_valid = r_o_valid;
    assign o_result_task  = r_o_res.task_id;
    assign o_event_res    = r_o_res.ev;
    assign o_first_run    = r_o_res.first;
    assign o_level        = r_o_res.level;
    assign o_remaining    = r_o_res.remaining;
    assign o_now          = r_o_now;
    assign o_last         = r_o_last;

endmodule
